// File: src/bsc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsc_pkg
// Shared types and constants for the sensor compensation block.
// ----------------------------------------------------------------------------
package bsc_pkg;

    localparam int unsigned CfgIdxW  = 3;
    localparam int unsigned CfgDataW = 48;

    localparam logic [CfgIdxW-1:0] CFG_TEMP      = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_PRESS_A   = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_PRESS_B   = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_PRESS_C   = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_HUM_A     = 3'd4;
    localparam logic [CfgIdxW-1:0] CFG_HUM_B     = 3'd5;
    localparam logic [CfgIdxW-1:0] CFG_HUM_PRES  = 3'd6;

    localparam logic [1:0] OP_TEMP  = 2'd0;
    localparam logic [1:0] OP_PRESS = 2'd1;
    localparam logic [1:0] OP_HUM   = 2'd2;
    localparam logic [1:0] OP_NONE  = 2'd3;

    // datapath micro-operations
    localparam logic [3:0] UOP_NOP  = 4'd0;
    localparam logic [3:0] UOP_LOAD = 4'd1;
    localparam logic [3:0] UOP_STEP = 4'd2;
    localparam logic [3:0] UOP_DIVS = 4'd3;
    localparam logic [3:0] UOP_DIVI = 4'd4;
    localparam logic [3:0] UOP_DONE = 4'd5;

    localparam logic [31:0] HUM_MAX = 32'd419430400;

    typedef struct packed {
        logic [3:0] uop;
        logic [4:0] step;
    } t_cmd;

    typedef struct packed {
        logic div_zero;
        logic div_done;
    } t_status;

    typedef struct packed {
        logic [47:0] temp;
        logic [47:0] press_a;
        logic [47:0] press_b;
        logic [47:0] press_c;
        logic [31:0] hum_a;
        logic [39:0] hum_b;
        logic        hum_present;
    } t_coeffs;

endpackage

// File: src/bsc_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsc_in_if / bsc_out_if
// Valid-ready channels for samples and results.
// ----------------------------------------------------------------------------
interface bsc_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [19:0] raw_sample;
    modport source (output valid, op, raw_sample, input ready);
    modport sink   (input valid, op, raw_sample, output ready);
endinterface

interface bsc_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] value;
    modport source (output valid, value, input ready);
    modport sink   (input valid, value, output ready);
endinterface

// File: src/bsc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsc_ctrl
// Sequencer: accepts a beat, steps the datapath, hands the result out.
// ----------------------------------------------------------------------------
module bsc_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    input  logic [1:0]          i_op,
    input  bsc_pkg::t_status    i_status,
    output bsc_pkg::t_cmd       o_cmd
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CALC = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_POST = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    localparam logic [4:0] TEMP_LAST  = 5'd6;
    localparam logic [4:0] PRE_LAST   = 5'd13;
    localparam logic [4:0] POST_LAST  = 5'd19;
    localparam logic [4:0] HUM_LAST   = 5'd14;

    logic [2:0] r_state, n_state;
    logic [4:0] r_step, n_step;
    logic [1:0] r_op, n_op;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_op    = r_op;
        o_cmd.uop  = bsc_pkg::UOP_NOP;
        o_cmd.step = r_step;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.uop = bsc_pkg::UOP_LOAD;
                    n_op      = i_op;
                    n_step    = '0;
                    n_state   = S_CALC;
                end
            end
            S_CALC: begin
                o_cmd.uop = bsc_pkg::UOP_STEP;
                n_step    = r_step + 5'd1;
                priority if (r_op == bsc_pkg::OP_TEMP && r_step == TEMP_LAST) begin
                    n_state = S_OUT;
                end else if (r_op == bsc_pkg::OP_HUM && r_step == HUM_LAST) begin
                    n_state = S_OUT;
                end else if (r_op == bsc_pkg::OP_PRESS && r_step == PRE_LAST) begin
                    n_state = S_DIV;
                end else if (r_op != bsc_pkg::OP_TEMP && r_op != bsc_pkg::OP_PRESS
                             && r_op != bsc_pkg::OP_HUM) begin
                    n_state = S_OUT;
                end else begin
                    n_state = S_CALC;
                end
            end
            S_DIV: begin
                if (i_status.div_zero) begin
                    n_state = S_OUT;
                end else if (i_status.div_done) begin
                    o_cmd.uop = bsc_pkg::UOP_DIVI;
                    n_state   = S_POST;
                end else begin
                    o_cmd.uop = bsc_pkg::UOP_DIVS;
                end
            end
            S_POST: begin
                o_cmd.uop = bsc_pkg::UOP_STEP;
                n_step    = r_step + 5'd1;
                if (r_step == POST_LAST) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                o_cmd.uop = bsc_pkg::UOP_DONE;
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
            r_op    <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_op    <= n_op;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("ready and valid together");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> o_out_valid)
        else $error("result dropped");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_in_ready && i_in_valid) |=> !o_in_ready)
        else $error("second beat taken");
endmodule

// File: src/bsc_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsc_datapath
// Shared multiplier, accumulator registers and a radix-2 divider.
// ----------------------------------------------------------------------------
module bsc_datapath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  bsc_pkg::t_cmd      i_cmd,
    input  bsc_pkg::t_coeffs   i_coeffs,
    input  logic [1:0]         i_op,
    input  logic [19:0]        i_raw,
    output bsc_pkg::t_status   o_status,
    output logic [31:0]        o_value
);
    logic [31:0] r_a, r_b, r_c, r_d, r_e, r_adc, r_res, r_tfine;
    logic [31:0] n_a, n_b, n_c, n_d, n_e, n_res, n_tfine;
    logic [1:0]  r_op;
    logic [31:0] r_q, r_rem, r_dvd;
    logic [5:0]  r_cnt;
    logic        r_big;
    logic [31:0] m_x, m_y, m_p;
    logic [32:0] rem_sh;
    logic [31:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [31:0] t1, t2, t3, h1, h2, h3, h4, h5, h6;

    function automatic logic [31:0] sx16(input logic [15:0] v);
        sx16 = {{16{v[15]}}, v};
    endfunction

    function automatic logic [31:0] asr(input logic [31:0] v, input logic [4:0] n);
        asr = 32'($signed(v) >>> n);
    endfunction

    assign t1 = {16'd0, i_coeffs.temp[15:0]};
    assign t2 = sx16(i_coeffs.temp[31:16]);
    assign t3 = sx16(i_coeffs.temp[47:32]);
    assign p1 = {16'd0, i_coeffs.press_a[15:0]};
    assign p2 = sx16(i_coeffs.press_a[31:16]);
    assign p3 = sx16(i_coeffs.press_a[47:32]);
    assign p4 = sx16(i_coeffs.press_b[15:0]);
    assign p5 = sx16(i_coeffs.press_b[31:16]);
    assign p6 = sx16(i_coeffs.press_b[47:32]);
    assign p7 = sx16(i_coeffs.press_c[15:0]);
    assign p8 = sx16(i_coeffs.press_c[31:16]);
    assign p9 = sx16(i_coeffs.press_c[47:32]);
    assign h1 = {24'd0, i_coeffs.hum_a[7:0]};
    assign h2 = sx16(i_coeffs.hum_a[23:8]);
    assign h3 = {24'd0, i_coeffs.hum_a[31:24]};
    assign h4 = sx16(i_coeffs.hum_b[15:0]);
    assign h5 = sx16(i_coeffs.hum_b[31:16]);
    assign h6 = {{24{i_coeffs.hum_b[39]}}, i_coeffs.hum_b[39:32]};

    // single shared 32x32 multiplier, low word
    assign m_p = m_x * m_y;

    assign o_status.div_zero = (r_e == 32'd0);
    assign o_status.div_done = (r_cnt == 6'd32);
    assign o_value = r_res;
    assign rem_sh  = {r_rem, r_dvd[31]};

    always_comb begin
        n_a = r_a; n_b = r_b; n_c = r_c; n_d = r_d; n_e = r_e;
        n_res = r_res; n_tfine = r_tfine;
        m_x = '0; m_y = '0;
        if (i_cmd.uop == bsc_pkg::UOP_LOAD) begin
            n_e   = 32'd1;
            n_res = '0;
        end else if (i_cmd.uop == bsc_pkg::UOP_STEP) begin
            unique case (r_op)
                bsc_pkg::OP_TEMP: begin
                    unique case (i_cmd.step)
                        5'd0: begin
                            n_a = (r_adc >> 3) - (t1 << 1);
                            n_b = (r_adc >> 4) - t1;
                        end
                        5'd1: begin m_x = r_a; m_y = t2; n_c = asr(m_p, 5'd11); end
                        5'd2: begin m_x = r_b; m_y = r_b; n_d = asr(m_p, 5'd12); end
                        5'd3: begin m_x = r_d; m_y = t3; n_d = asr(m_p, 5'd14); end
                        5'd4: n_tfine = r_c + r_d;
                        5'd5: begin m_x = r_tfine; m_y = 32'd5; n_a = m_p + 32'd128; end
                        5'd6: n_res = asr(r_a, 5'd8);
                        default: ;
                    endcase
                end
                bsc_pkg::OP_PRESS: begin
                    unique case (i_cmd.step)
                        5'd0: n_a = asr(r_tfine, 5'd1) - 32'd64000;
                        5'd1: begin m_x = asr(r_a, 5'd2); m_y = asr(r_a, 5'd2); n_b = m_p; end
                        5'd2: begin m_x = asr(r_b, 5'd11); m_y = p6; n_c = m_p; end
                        5'd3: begin m_x = r_a; m_y = p5; n_c = r_c + (m_p << 1); end
                        5'd4: n_c = asr(r_c, 5'd2) + (p4 << 16);
                        5'd5: begin m_x = p3; m_y = asr(r_b, 5'd13); n_d = asr(m_p, 5'd3); end
                        5'd6: begin m_x = p2; m_y = r_a; n_d = r_d + asr(m_p, 5'd1); end
                        5'd7: n_d = 32'd32768 + asr(r_d, 5'd18);
                        5'd8: begin m_x = r_d; m_y = p1; n_e = asr(m_p, 5'd15); end
                        5'd9: n_d = (32'd1048576 - r_adc) - asr(r_c, 5'd12);
                        5'd10: begin m_x = r_d; m_y = 32'd3125; n_d = m_p; end
                        5'd11, 5'd12, 5'd13: ;
                        5'd14: begin m_x = r_a >> 3; m_y = r_a >> 3; n_b = m_p >> 13; end
                        5'd15: begin m_x = p9; m_y = r_b; n_b = asr(m_p, 5'd12); end
                        5'd16: begin m_x = r_a >> 2; m_y = p8; n_c = asr(m_p, 5'd13); end
                        5'd17: n_c = r_b + r_c + p7;
                        5'd18: n_res = r_a + asr(r_c, 5'd4);
                        default: ;
                    endcase
                end
                bsc_pkg::OP_HUM: begin
                    unique case (i_cmd.step)
                        5'd0: n_a = r_tfine - 32'd76800;
                        5'd1: begin m_x = h5; m_y = r_a; n_b = ({16'd0, r_adc[15:0]} << 14)
                                  - (h4 << 20) - m_p; end
                        5'd2: n_b = asr(r_b + 32'd16384, 5'd15);
                        5'd3: begin m_x = r_a; m_y = h6; n_c = asr(m_p, 5'd10); end
                        5'd4: begin m_x = r_a; m_y = h3; n_d = asr(m_p, 5'd11) + 32'd32768; end
                        5'd5: begin m_x = r_c; m_y = r_d; n_c = asr(m_p, 5'd10) + 32'd2097152; end
                        5'd6: begin m_x = r_c; m_y = h2; n_c = asr(m_p + 32'd8192, 5'd14); end
                        5'd7: begin m_x = r_b; m_y = r_c; n_d = m_p; end
                        5'd8: begin m_x = asr(r_d, 5'd15); m_y = asr(r_d, 5'd15);
                                  n_c = asr(m_p, 5'd7); end
                        5'd9: begin m_x = r_c; m_y = h1; n_d = r_d - asr(m_p, 5'd4); end
                        5'd10: begin
                            if (r_d[31]) n_d = '0;
                            else if (r_d > bsc_pkg::HUM_MAX) n_d = bsc_pkg::HUM_MAX;
                        end
                        5'd11, 5'd12, 5'd13: ;
                        5'd14: n_res = i_coeffs.hum_present ? (r_d >> 12) : 32'hFFFF_FFFF;
                        default: ;
                    endcase
                end
                default: n_res = '0;
            endcase
        end else if (i_cmd.uop == bsc_pkg::UOP_DIVI) begin
            n_a   = r_big ? (r_q << 1) : r_q;
            n_e   = r_e;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tfine <= '0;
        end else begin
            r_tfine <= n_tfine;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a <= n_a; r_b <= n_b; r_c <= n_c; r_d <= n_d; r_e <= n_e;
        r_res <= n_res;
        unique case (i_cmd.uop)
            bsc_pkg::UOP_LOAD: begin
                r_op  <= i_op;
                r_adc <= {12'd0, i_raw};
                r_cnt <= 6'd32;
            end
            bsc_pkg::UOP_STEP: begin
                if (r_op == bsc_pkg::OP_PRESS && i_cmd.step == 5'd10) begin
                    r_cnt <= '0;
                    r_rem <= '0;
                    r_q   <= '0;
                    r_big <= m_p[31];
                    r_dvd <= m_p[31] ? m_p : (m_p << 1);
                end
            end
            bsc_pkg::UOP_DIVS: begin
                // restoring divide, one quotient bit per cycle
                if (rem_sh >= {1'b0, r_e}) begin
                    r_rem <= 32'(rem_sh - {1'b0, r_e});
                    r_q   <= {r_q[30:0], 1'b1};
                end else begin
                    r_rem <= rem_sh[31:0];
                    r_q   <= {r_q[30:0], 1'b0};
                end
                r_dvd <= r_dvd << 1;
                r_cnt <= r_cnt + 6'd1;
            end
            default: ;
        endcase
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.uop == bsc_pkg::UOP_DIVS) |-> (r_cnt < 6'd32))
        else $error("divider overrun");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.uop == bsc_pkg::UOP_DIVS) |-> (r_e != 32'd0))
        else $error("divide by zero stepped");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.uop == bsc_pkg::UOP_LOAD) |=> $stable(r_tfine))
        else $error("fine temperature changed on load");
endmodule

// File: src/barometric_sensor_compensation.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// barometric_sensor_compensation
// Integer calibration of temperature, pressure and humidity samples.
// ----------------------------------------------------------------------------
// One beat at a time. Temperature and humidity results come from the step
// sequence alone. Pressure adds a restoring divider, which is skipped with a
// result of 0 when the pressure divisor is zero; an undefined op gives 0. A
// single shared 32x32 multiplier runs one product per cycle. The result
// register holds until taken and the input is ready again in the cycle after
// the result beat.
module barometric_sensor_compensation (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [bsc_pkg::CfgIdxW-1:0]       i_cfg_index,
    input  logic [bsc_pkg::CfgDataW-1:0]      i_cfg_data,
    bsc_in_if.sink                            s_in,
    bsc_out_if.source                         m_out
);
    bsc_pkg::t_coeffs r_coeffs;
    bsc_pkg::t_cmd    cmd;
    bsc_pkg::t_status status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coeffs <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                bsc_pkg::CFG_TEMP:     r_coeffs.temp        <= i_cfg_data;
                bsc_pkg::CFG_PRESS_A:  r_coeffs.press_a     <= i_cfg_data;
                bsc_pkg::CFG_PRESS_B:  r_coeffs.press_b     <= i_cfg_data;
                bsc_pkg::CFG_PRESS_C:  r_coeffs.press_c     <= i_cfg_data;
                bsc_pkg::CFG_HUM_A:    r_coeffs.hum_a       <= i_cfg_data[31:0];
                bsc_pkg::CFG_HUM_B:    r_coeffs.hum_b       <= i_cfg_data[39:0];
                bsc_pkg::CFG_HUM_PRES: r_coeffs.hum_present <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    bsc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_in.valid),
        .o_in_ready  (s_in.ready),
        .o_out_valid (m_out.valid),
        .i_out_ready (m_out.ready),
        .i_op        (s_in.op),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    bsc_datapath u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_coeffs (r_coeffs),
        .i_op     (s_in.op),
        .i_raw    (s_in.raw_sample),
        .o_status (status),
        .o_value  (m_out.value)
    );
endmodule

// File: tb/bsc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsc_checker
// Watches the sample and result channels of the compensation block. Every
// accepted sample runs through an integer model of the calibration formulas,
// which keeps its own coefficients and fine temperature. Every accepted result
// is compared with the oldest predicted value.
// ----------------------------------------------------------------------------
module bsc_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [bsc_pkg::CfgIdxW-1:0]   i_cfg_index,
    input  logic [bsc_pkg::CfgDataW-1:0]  i_cfg_data,
    bsc_in_if.sink                        s_in,
    bsc_out_if.sink                       m_out,
    output int                            o_errors,
    output int                            o_pending
);
    bsc_pkg::t_coeffs coef;
    logic [31:0]      t_fine;
    logic [31:0]      value_q[$];

    assign o_pending = value_q.size();

    function automatic logic [31:0] asr(logic [31:0] v, int n);
        return 32'($signed(v) >>> n);
    endfunction

    function automatic logic [31:0] sx16(logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    function automatic logic [31:0] calc_temp(logic [19:0] adc);
        logic [31:0] c1, c2, c3, a, b, v1, v2;
        c1 = {16'd0, coef.temp[15:0]};
        c2 = sx16(coef.temp[31:16]);
        c3 = sx16(coef.temp[47:32]);
        a  = ({12'd0, adc} >> 3) - (c1 << 1);
        b  = ({12'd0, adc} >> 4) - c1;
        v1 = asr(a * c2, 11);
        v2 = asr(asr(b * b, 12) * c3, 14);
        t_fine = v1 + v2;
        return asr(t_fine * 32'd5 + 32'd128, 8);
    endfunction

    function automatic logic [31:0] calc_press(logic [19:0] adc);
        logic [31:0] p1, p2, p3, p4, p5, p6, p7, p8, p9, v1, v2, sq, p;
        p1 = {16'd0, coef.press_a[15:0]};
        p2 = sx16(coef.press_a[31:16]);
        p3 = sx16(coef.press_a[47:32]);
        p4 = sx16(coef.press_b[15:0]);
        p5 = sx16(coef.press_b[31:16]);
        p6 = sx16(coef.press_b[47:32]);
        p7 = sx16(coef.press_c[15:0]);
        p8 = sx16(coef.press_c[31:16]);
        p9 = sx16(coef.press_c[47:32]);
        v1 = asr(t_fine, 1) - 32'd64000;
        sq = asr(v1, 2) * asr(v1, 2);
        v2 = asr(sq, 11) * p6;
        v2 = v2 + ((v1 * p5) << 1);
        v2 = asr(v2, 2) + (p4 << 16);
        v1 = asr(asr(p3 * asr(sq, 13), 3) + asr(p2 * v1, 1), 18);
        v1 = asr((32'd32768 + v1) * p1, 15);
        if (v1 == 0) return 32'd0;
        p = ((32'd1048576 - {12'd0, adc}) - asr(v2, 12)) * 32'd3125;
        if (p < 32'h8000_0000) p = (p << 1) / v1;
        else p = (p / v1) << 1;
        v1 = asr(p9 * (((p >> 3) * (p >> 3)) >> 13), 12);
        v2 = asr((p >> 2) * p8, 13);
        return p + asr(v1 + v2 + p7, 4);
    endfunction

    function automatic logic [31:0] calc_hum(logic [19:0] adc);
        logic [31:0] h1, h2, h3, h4, h5, h6, x, lft, inner, rgt, v, a16;
        if (!coef.hum_present) return 32'hFFFF_FFFF;
        h1 = {24'd0, coef.hum_a[7:0]};
        h2 = sx16(coef.hum_a[23:8]);
        h3 = {24'd0, coef.hum_a[31:24]};
        h4 = sx16(coef.hum_b[15:0]);
        h5 = sx16(coef.hum_b[31:16]);
        h6 = {{24{coef.hum_b[39]}}, coef.hum_b[39:32]};
        a16 = {16'd0, adc[15:0]};
        x = t_fine - 32'd76800;
        lft = asr(((a16 << 14) - (h4 << 20) - h5 * x) + 32'd16384, 15);
        inner = asr(asr(x * h6, 10) * (asr(x * h3, 11) + 32'd32768), 10) + 32'd2097152;
        rgt = asr(inner * h2 + 32'd8192, 14);
        v = lft * rgt;
        v = v - asr(asr(asr(v, 15) * asr(v, 15), 7) * h1, 4);
        if (v[31]) v = 0;
        else if (v > bsc_pkg::HUM_MAX) v = bsc_pkg::HUM_MAX;
        return v >> 12;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t MISMATCH: %s", $realtime, msg);
        o_errors++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            coef     <= '0;
            t_fine   = '0;
            o_errors = 0;
            value_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    bsc_pkg::CFG_TEMP:     coef.temp        <= i_cfg_data;
                    bsc_pkg::CFG_PRESS_A:  coef.press_a     <= i_cfg_data;
                    bsc_pkg::CFG_PRESS_B:  coef.press_b     <= i_cfg_data;
                    bsc_pkg::CFG_PRESS_C:  coef.press_c     <= i_cfg_data;
                    bsc_pkg::CFG_HUM_A:    coef.hum_a       <= i_cfg_data[31:0];
                    bsc_pkg::CFG_HUM_B:    coef.hum_b       <= i_cfg_data[39:0];
                    bsc_pkg::CFG_HUM_PRES: coef.hum_present <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (s_in.valid && s_in.ready) begin
                case (s_in.op)
                    bsc_pkg::OP_TEMP:  value_q.push_back(calc_temp(s_in.raw_sample));
                    bsc_pkg::OP_PRESS: value_q.push_back(calc_press(s_in.raw_sample));
                    bsc_pkg::OP_HUM:   value_q.push_back(calc_hum(s_in.raw_sample));
                    default:           value_q.push_back(32'd0);
                endcase
            end
            if (m_out.valid && m_out.ready) begin
                if (value_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected beat value %h", m_out.value));
                end else if (m_out.value !== value_q[0]) begin
                    report_mismatch($sformatf("value got %h want %h",
                                              m_out.value, value_q[0]));
                    void'(value_q.pop_front());
                end else begin
                    void'(value_q.pop_front());
                end
            end
        end
    end
endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the compensation block: coefficient sets from zero to all ones
// and realistic values, directed samples for every operation and corner case,
// then random mixed samples with random gaps and result stalls.
// ----------------------------------------------------------------------------
module tb_top;
    logic                         i_clk;
    logic                         i_rst_n;
    logic                         i_cfg_we;
    logic [bsc_pkg::CfgIdxW-1:0]  i_cfg_index;
    logic [bsc_pkg::CfgDataW-1:0] i_cfg_data;
    int                           errors;
    int                           pending;
    int                           cycles;
    int                           idle_pct;
    int                           hold_off;

    bsc_in_if  in_ch();
    bsc_out_if out_ch();

    barometric_sensor_compensation u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .s_in(in_ch.sink), .m_out(out_ch.source)
    );

    bsc_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .s_in(in_ch.sink), .m_out(out_ch.sink),
        .o_errors(errors), .o_pending(pending)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // result side stalls
    always @(posedge i_clk) begin
        if (hold_off > 0) begin
            out_ch.ready <= 1'b0;
            hold_off     <= hold_off - 1;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= idle_pct);
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 600000) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // leaves the write enable high; the caller drops it after the last write
    task automatic write_cfg(input logic [bsc_pkg::CfgIdxW-1:0] idx,
                             input logic [bsc_pkg::CfgDataW-1:0] d);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= d;
        @(posedge i_clk);
    endtask

    task automatic settle();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    task automatic load_coeffs(input int kind);
        logic [47:0] w[7];
        for (int i = 0; i < 7; i++) begin
            case (kind)
                0: w[i] = '0;
                1: w[i] = '1;
                2: w[i] = 48'({$urandom, $urandom});
                default: w[i] = '0;
            endcase
        end
        if (kind == 3) begin
            // typical calibration
            w[0] = {16'd50, 16'd26435, 16'd27504};
            w[1] = {16'd6000, -16'sd10685, 16'd36477};
            w[2] = {-16'sd7, 16'd140, 16'd2855};
            w[3] = {16'd6000, -16'sd14600, 16'd15500};
            w[4] = {16'd0, 8'd0, 16'd361, 8'd75};
            w[5] = {16'd0, 16'd50, 16'd313};
            w[6] = 48'd1;
        end
        if (kind == 2) w[6] = 48'($urandom_range(1));
        write_cfg(bsc_pkg::CFG_TEMP, w[0]);
        write_cfg(bsc_pkg::CFG_PRESS_A, w[1]);
        write_cfg(bsc_pkg::CFG_PRESS_B, w[2]);
        write_cfg(bsc_pkg::CFG_PRESS_C, w[3]);
        write_cfg(bsc_pkg::CFG_HUM_A, w[4]);
        write_cfg(bsc_pkg::CFG_HUM_B, w[5]);
        write_cfg(bsc_pkg::CFG_HUM_PRES, w[6]);
        i_cfg_we <= 1'b0;
    endtask

    // valid stays high after the beat until the next gap or settle
    task automatic send(input logic [1:0] op, input logic [19:0] raw);
        while ($urandom_range(99) < idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.op         <= op;
        in_ch.raw_sample <= raw;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    task automatic send_random(input int n);
        logic [1:0]  op;
        logic [19:0] raw;
        for (int i = 0; i < n; i++) begin
            op  = ($urandom_range(19) == 0) ? bsc_pkg::OP_NONE : 2'($urandom_range(2));
            raw = ($urandom_range(3) == 0) ? 20'($urandom_range(1) ? '1 : 0)
                                           : 20'($urandom);
            if (op == bsc_pkg::OP_TEMP && $urandom_range(1))
                raw = 20'($urandom_range(400000, 600000));
            send(op, raw);
        end
    endtask

    initial begin
        i_rst_n          = 0;
        i_cfg_we         = 0;
        i_cfg_index      = '0;
        i_cfg_data       = '0;
        in_ch.valid      = 0;
        in_ch.op         = bsc_pkg::OP_TEMP;
        in_ch.raw_sample = '0;
        out_ch.ready     = 0;
        cycles           = 0;
        hold_off         = 0;
        idle_pct         = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: all-zero coefficients give a zero divisor and no humidity
        send(bsc_pkg::OP_PRESS, 20'd0);
        send(bsc_pkg::OP_HUM, 20'hFFFFF);
        send(bsc_pkg::OP_NONE, 20'h12345);
        send(bsc_pkg::OP_TEMP, 20'd0);
        settle();
        load_coeffs(3);
        idle_pct = 26;
        send(bsc_pkg::OP_TEMP, 20'd519888);
        send(bsc_pkg::OP_PRESS, 20'd415148);
        send(bsc_pkg::OP_HUM, 20'h1_7A2C);
        send(bsc_pkg::OP_PRESS, 20'd0);
        send(bsc_pkg::OP_PRESS, 20'hFFFFF);
        send(bsc_pkg::OP_HUM, 20'd0);
        send(bsc_pkg::OP_HUM, 20'h0FFFF);
        send(bsc_pkg::OP_TEMP, 20'hFFFFF);
        send(bsc_pkg::OP_PRESS, 20'd300000);
        send(bsc_pkg::OP_HUM, 20'd40000);
        send(bsc_pkg::OP_NONE, 20'hFFFFF);
        send(bsc_pkg::OP_TEMP, 20'd0);
        send(bsc_pkg::OP_PRESS, 20'd500000);
        send(bsc_pkg::OP_HUM, 20'd30000);
        settle();
        load_coeffs(1);
        send(bsc_pkg::OP_TEMP, 20'hAAAAA);
        send(bsc_pkg::OP_PRESS, 20'h55555);
        send(bsc_pkg::OP_HUM, 20'hFFFFF);
        settle();

        // long result stall while samples keep coming
        load_coeffs(3);
        hold_off = 400;
        send_random(6);
        settle();

        // no idling stretch
        idle_pct = 0;
        send_random(60);
        settle();
        idle_pct = 26;
        for (int ph = 0; ph < 6; ph++) begin
            load_coeffs(ph % 2 == 0 ? 3 : 2);
            send_random(70);
            settle();
        end

        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule
